/* sv/lvnc_pkg.sv */
// ============================================================================
// lvnc_pkg
// Shared widths, register indexes, reset values, types and the reciprocal
// table used by the local variance noise counter.
// ============================================================================
package lvnc_pkg;

    localparam int PIX_W       = 8;
    localparam int COUNT_W     = 23;
    localparam int GEOM_W      = 12;
    localparam int DEV_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 23;
    localparam int SUM_W       = 12;
    localparam int CNT_W       = 4;
    localparam int RECIP_W     = 17;
    localparam int RECIP_SHIFT = 16;
    localparam int LINE_W      = 2 * PIX_W;
    localparam int OUT_W       = 24;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEV_LIMIT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_LIMIT  = 2'd3;

    // register values after reset
    localparam logic [GEOM_W-1:0]  RST_FRAME_WIDTH  = 12'd1920;
    localparam logic [GEOM_W-1:0]  RST_FRAME_HEIGHT = 12'd1200;
    localparam logic [DEV_W-1:0]   RST_DEV_LIMIT    = 16'd100;
    localparam logic [COUNT_W-1:0] RST_COUNT_LIMIT  = 23'd92160;

    localparam logic [COUNT_W-1:0] TALLY_MAX = '1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COL,
        S_PAD,
        S_SWEEP,
        S_SWLAST,
        S_DRAIN,
        S_DONE
    } t_state;

    // 3x3 window handed to the judge pipeline, index = row * 3 + column
    typedef struct packed {
        logic                   req;
        logic [8:0]             mask;
        logic [8:0][PIX_W-1:0]  pix;
    } t_judge_req;

    typedef struct packed {
        logic busy;
        logic hit;
    } t_judge_stat;

    // floor(2^16 / n) for the neighbour counts that can occur
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] m;
        case (cnt)
            4'd2:    m = 17'd32768;
            4'd3:    m = 17'd21845;
            4'd4:    m = 17'd16384;
            4'd5:    m = 17'd13107;
            4'd6:    m = 17'd10922;
            4'd7:    m = 17'd9362;
            4'd8:    m = 17'd8192;
            4'd9:    m = 17'd7281;
            default: m = 17'd65536;
        endcase
        return m;
    endfunction

endpackage

/* sv/lvnc_ram.sv */
// ============================================================================
// lvnc_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ============================================================================
module lvnc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, registered output
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* sv/lvnc_judge.sv */
// ============================================================================
// lvnc_judge
// Four-stage pipeline: window sum and count, reciprocal multiply, quotient
// correction and absolute deviation, square and threshold compare.
// ============================================================================
module lvnc_judge (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lvnc_pkg::t_judge_req            i_req,
    input  logic [lvnc_pkg::DEV_W-1:0]      i_dev_limit,
    output lvnc_pkg::t_judge_stat           o_stat
);

    localparam int PW = lvnc_pkg::PIX_W;
    localparam int SW = lvnc_pkg::SUM_W;
    localparam int CW = lvnc_pkg::CNT_W;
    localparam int BW = lvnc_pkg::SUM_W + lvnc_pkg::RECIP_W;
    localparam int MW = lvnc_pkg::SUM_W + lvnc_pkg::CNT_W;
    localparam int DW = lvnc_pkg::DEV_W;

    logic          r_a_v, r_b_v, r_c_v, r_d_hit;
    logic [SW-1:0] r_a_sum, r_b_sum, r_b_q0;
    logic [CW-1:0] r_a_cnt, r_b_cnt;
    logic [PW-1:0] r_a_pix, r_b_pix, r_c_d;

    logic [SW-1:0] a_sum;
    logic [CW-1:0] a_cnt;
    logic [BW-1:0] b_prod;
    logic [MW-1:0] c_prod, c_rem;
    logic          c_corr;
    logic [PW-1:0] c_mean, c_d;
    logic [DW-1:0] d_sq;

    // sum and count the in-image neighbours
    always_comb begin
        a_sum = '0;
        for (int i = 0; i < 9; i++) begin
            a_sum = a_sum + (i_req.mask[i] ? SW'(i_req.pix[i]) : SW'(0));
        end
        a_cnt = CW'($countones(i_req.mask));
    end

    // quotient estimate, at most one below the true value
    assign b_prod = BW'(r_a_sum) * BW'(lvnc_pkg::recip(r_a_cnt));

    // correct the quotient and take the deviation
    always_comb begin
        c_prod = MW'(r_b_q0) * MW'(r_b_cnt);
        c_rem  = MW'(r_b_sum) - c_prod;
        c_corr = (c_rem >= MW'(r_b_cnt));
        c_mean = PW'(r_b_q0 + SW'(c_corr));
        c_d    = (r_b_pix >= c_mean) ? (r_b_pix - c_mean) : (c_mean - r_b_pix);
    end

    assign d_sq = DW'(r_c_d) * DW'(r_c_d);

    // stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v   <= 1'b0;
            r_b_v   <= 1'b0;
            r_c_v   <= 1'b0;
            r_d_hit <= 1'b0;
        end else begin
            r_a_v   <= i_req.req;
            r_b_v   <= r_a_v;
            r_c_v   <= r_b_v;
            r_d_hit <= r_c_v && (d_sq > i_dev_limit);
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        r_a_sum <= a_sum;
        r_a_cnt <= a_cnt;
        r_a_pix <= i_req.pix[4];
        r_b_sum <= r_a_sum;
        r_b_cnt <= r_a_cnt;
        r_b_pix <= r_a_pix;
        r_b_q0  <= SW'(b_prod >> lvnc_pkg::RECIP_SHIFT);
        r_c_d   <= c_d;
    end

    assign o_stat.busy = r_a_v | r_b_v | r_c_v | r_d_hit;
    assign o_stat.hit  = r_d_hit;

endmodule

/* sv/local_variance_noise_counter.sv */
// ============================================================================
// local_variance_noise_counter
// Counts pixels whose squared deviation from their 3x3 neighbourhood mean
// exceeds a limit and reports the count and a noisy flag once per frame.
// ============================================================================
// Pixel flow: line memory read, then write-back and window shift, plus a padding
//   shift at each row end from the second row on; a new pixel waits for the last.
// Frame end: after the last pixel the last row is re-read from the line
//   memory, then the judge pipeline drains before the result is loaded into
//   the output register.
// Reset: synchronous, active low; clears control, counters and configuration
//   registers to their defaults. The line memory is not cleared.
module local_variance_noise_counter #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [lvnc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lvnc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [lvnc_pkg::PIX_W-1:0]          i_s_tdata,   // [7:0] pixel
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [lvnc_pkg::OUT_W-1:0]          o_m_tdata    // [22:0] noisy_count,
                                                              // [23] noise_found
);

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int CWW = $clog2(MAX_WIDTH + 1);
    localparam int GW  = (CWW > lvnc_pkg::GEOM_W) ? CWW : lvnc_pkg::GEOM_W;
    localparam int HW  = lvnc_pkg::GEOM_W;
    localparam int PW  = lvnc_pkg::PIX_W;
    localparam int LW  = lvnc_pkg::LINE_W;
    localparam int NW  = lvnc_pkg::COUNT_W;

    // configuration registers
    logic [HW-1:0]              r_frame_width, r_frame_height;
    logic [lvnc_pkg::DEV_W-1:0] r_dev_limit;
    logic [NW-1:0]              r_count_limit;

    // frame geometry and position
    logic [CWW-1:0] r_cur_w;
    logic [HW-1:0]  r_cur_h;
    logic [AW-1:0]  r_col, r_c, r_sk;
    logic [HW-1:0]  r_row, r_r;
    logic [PW-1:0]  r_pix;

    lvnc_pkg::t_state r_state, n_state;
    logic             r_sweep, r_rdv, r_rd_first;

    // window: column 0 is newest, row 0 is top
    logic [2:0][2:0][PW-1:0] r_win;
    logic [2:0]              r_colv, r_rowv;
    logic                    r_jreq;

    logic [NW-1:0] r_tally;
    logic          r_m_tvalid;
    logic [lvnc_pkg::OUT_W-1:0] r_m_tdata;

    // combinational control
    logic                 s_ready, rd_en, wr_en, out_free;
    logic [AW-1:0]        rd_addr;
    logic [LW-1:0]        rd_data;
    logic                 sh, sh_first, sh_colv, sh_judge;
    logic [2:0][PW-1:0]   sh_col;
    logic [2:0]           sh_rowv;
    logic [GW-1:0]        fw;
    logic [CWW-1:0]       geo_w;
    logic [HW-1:0]        geo_h;
    logic                 row_end, last_row, r_ge1, r_ge2, c_ge1, sweep_last;

    lvnc_pkg::t_judge_req  jreq;
    lvnc_pkg::t_judge_stat jstat;

    // geometry as latched at the first pixel of a frame
    always_comb begin
        fw = GW'(r_frame_width);
        if (fw == '0) begin
            fw = GW'(1);
        end else if (fw > GW'(MAX_WIDTH)) begin
            fw = GW'(MAX_WIDTH);
        end
        geo_w = CWW'(fw);
        geo_h = (r_frame_height == '0) ? HW'(1) : r_frame_height;
    end

    // position flags of the item at work
    assign row_end    = (CWW'(r_c) + CWW'(1)) == r_cur_w;
    assign last_row   = ((HW + 1)'(r_r) + (HW + 1)'(1)) >= (HW + 1)'(r_cur_h);
    assign r_ge1      = (r_r != '0);
    assign r_ge2      = (r_r > HW'(1));
    assign c_ge1      = (r_c != '0);
    assign sweep_last = (CWW'(r_sk) + CWW'(1)) == r_cur_w;
    assign out_free   = !r_m_tvalid || i_m_tready;

    // next state and per-state controls
    always_comb begin
        n_state  = r_state;
        s_ready  = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = r_col;
        wr_en    = 1'b0;
        sh       = 1'b0;
        sh_first = 1'b0;
        sh_col   = '0;
        sh_colv  = 1'b0;
        sh_rowv  = r_rowv;
        sh_judge = 1'b0;
        case (r_state)
            lvnc_pkg::S_IDLE: begin
                s_ready = 1'b1;
                rd_en   = i_s_tvalid;
                if (i_s_tvalid) begin
                    n_state = lvnc_pkg::S_COL;
                end
            end
            lvnc_pkg::S_COL: begin
                wr_en     = 1'b1;
                sh        = 1'b1;
                sh_first  = !c_ge1;
                sh_col[0] = rd_data[PW-1:0];
                sh_col[1] = rd_data[LW-1:PW];
                sh_col[2] = r_pix;
                sh_colv   = 1'b1;
                sh_rowv   = {1'b1, r_ge1, r_ge2};
                sh_judge  = r_ge1 && c_ge1;
                if (row_end && r_ge1) begin
                    n_state = lvnc_pkg::S_PAD;
                end else if (row_end && last_row) begin
                    n_state = lvnc_pkg::S_SWEEP;
                end else begin
                    n_state = lvnc_pkg::S_IDLE;
                end
            end
            lvnc_pkg::S_PAD: begin
                sh       = 1'b1;
                sh_judge = 1'b1;
                if (r_sweep) begin
                    n_state = lvnc_pkg::S_DRAIN;
                end else if (last_row) begin
                    n_state = lvnc_pkg::S_SWEEP;
                end else begin
                    n_state = lvnc_pkg::S_IDLE;
                end
            end
            lvnc_pkg::S_SWEEP, lvnc_pkg::S_SWLAST: begin
                if (r_state == lvnc_pkg::S_SWEEP) begin
                    rd_en   = 1'b1;
                    rd_addr = r_sk;
                    if (sweep_last) begin
                        n_state = lvnc_pkg::S_SWLAST;
                    end
                end else begin
                    n_state = lvnc_pkg::S_PAD;
                end
                if (r_rdv) begin
                    sh        = 1'b1;
                    sh_first  = r_rd_first;
                    sh_col[0] = rd_data[PW-1:0];
                    sh_col[1] = rd_data[LW-1:PW];
                    sh_colv   = 1'b1;
                    sh_rowv   = {1'b0, 1'b1, r_ge1};
                    sh_judge  = !r_rd_first;
                end
            end
            lvnc_pkg::S_DRAIN: begin
                if (!r_jreq && !jstat.busy) begin
                    n_state = lvnc_pkg::S_DONE;
                end
            end
            lvnc_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = lvnc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lvnc_pkg::S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lvnc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= lvnc_pkg::RST_FRAME_WIDTH;
            r_frame_height <= lvnc_pkg::RST_FRAME_HEIGHT;
            r_dev_limit    <= lvnc_pkg::RST_DEV_LIMIT;
            r_count_limit  <= lvnc_pkg::RST_COUNT_LIMIT;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                lvnc_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_wdata[HW-1:0];
                lvnc_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_wdata[HW-1:0];
                lvnc_pkg::CFG_DEV_LIMIT:    r_dev_limit    <= i_cfg_wdata[lvnc_pkg::DEV_W-1:0];
                lvnc_pkg::CFG_COUNT_LIMIT:  r_count_limit  <= i_cfg_wdata[NW-1:0];
                default: ;
            endcase
        end
    end

    // latch the beat, geometry at frame start, advance position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_w <= geo_w;
            r_cur_h <= geo_h;
            r_col   <= '0;
            r_row   <= '0;
            r_c     <= '0;
            r_r     <= '0;
        end else if (r_state == lvnc_pkg::S_IDLE && i_s_tvalid) begin
            r_c <= r_col;
            r_r <= r_row;
            if (r_row == '0 && r_col == '0) begin
                r_cur_w <= geo_w;
                r_cur_h <= geo_h;
            end
        end else if (r_state == lvnc_pkg::S_COL) begin
            if (row_end) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_r + HW'(1);
            end else begin
                r_col <= r_c + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == lvnc_pkg::S_IDLE && i_s_tvalid) begin
            r_pix <= i_s_tdata;
        end
    end

    // sweep address and read tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sk       <= '0;
            r_rdv      <= 1'b0;
            r_rd_first <= 1'b0;
            r_sweep    <= 1'b0;
        end else begin
            r_sk       <= (r_state == lvnc_pkg::S_SWEEP) ? r_sk + AW'(1) : '0;
            r_rdv      <= (r_state == lvnc_pkg::S_SWEEP);
            r_rd_first <= (r_sk == '0);
            if (r_state == lvnc_pkg::S_SWEEP) begin
                r_sweep <= 1'b1;
            end else if (r_state == lvnc_pkg::S_DONE) begin
                r_sweep <= 1'b0;
            end
        end
    end

    // shift the window, drop older columns at a row start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_colv <= '0;
            r_rowv <= '0;
            r_jreq <= 1'b0;
        end else begin
            r_jreq <= sh && sh_judge;
            if (sh) begin
                r_colv <= {(sh_first ? 1'b0 : r_colv[1]), (sh_first ? 1'b0 : r_colv[0]),
                           sh_colv};
                r_rowv <= sh_rowv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (sh) begin
            r_win[2] <= r_win[1];
            r_win[1] <= r_win[0];
            r_win[0] <= sh_col;
        end
    end

    // present the window to the judge pipeline
    always_comb begin
        jreq.req = r_jreq;
        for (int y = 0; y < 3; y++) begin
            for (int x = 0; x < 3; x++) begin
                jreq.pix[y * 3 + x]  = r_win[2 - x][y];
                jreq.mask[y * 3 + x] = r_rowv[y] & r_colv[2 - x];
            end
        end
    end

    lvnc_judge u_judge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (jreq),
        .i_dev_limit (r_dev_limit),
        .o_stat      (jstat)
    );

    // two previous rows per column: high byte is the row just above
    lvnc_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_c),
        .i_wr_data ({r_pix, rd_data[LW-1:PW]}),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // saturating noisy tally, cleared as the result is loaded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tally <= '0;
        end else if (r_state == lvnc_pkg::S_DONE && out_free) begin
            r_tally <= '0;
        end else if (jstat.hit && r_tally != lvnc_pkg::TALLY_MAX) begin
            r_tally <= r_tally + NW'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (r_state == lvnc_pkg::S_DONE && out_free) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == lvnc_pkg::S_DONE && out_free) begin
            r_m_tdata <= {(r_tally > r_count_limit), r_tally};
        end
    end

    assign o_s_tready = s_ready;
    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;

endmodule

/* sv/lvnc_checker.sv */
// ============================================================================
// lvnc_checker
// Port-level checks of the local variance noise counter, bound to the top.
// ============================================================================
module lvnc_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_tvalid,
    input logic                             o_s_tready,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [lvnc_pkg::OUT_W-1:0]       o_m_tdata
);

    // a stalled result beat holds its data
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result beat changed while stalled");

    // reset leaves no result pending
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // reset leaves the input side ready
    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_tready)
        else $error("input not ready after reset");

    // an accepted pixel beat is followed by its write-back, during which the input is not ready
    a_accept_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input ready right after an accepted beat");

endmodule

bind local_variance_noise_counter lvnc_checker u_lvnc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_s_tvalid  (i_s_tvalid),
    .o_s_tready  (o_s_tready),
    .o_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .o_m_tdata   (o_m_tdata)
);

/* bench/tb_local_variance_noise_counter.sv */
// ----------------------------------------------------------------------------
// tb_local_variance_noise_counter
// Streams grey frames of many sizes into the noise counter and checks each
// per-frame noisy count and noise flag against a pixel-level predictor.
// Register settings change between frames only, and both stream sides idle
// at random.
// ----------------------------------------------------------------------------
module tb_local_variance_noise_counter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_MAX     = 2048;
    localparam int SETTLE_WAIT  = 16;
    localparam int DRAIN_WAIT   = 64;
    localparam int LONG_HOLD    = 500;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RAND_PIXELS  = 1400;
    localparam int RAND_FRAMES  = 40;
    localparam int DATA_W       = lvnc_pkg::CFG_DATA_W;
    localparam int PW           = lvnc_pkg::PIX_W;

    typedef struct {
        logic [lvnc_pkg::COUNT_W-1:0] noisy_count;
        logic                         noise_found;
    } t_frame_result;

    logic                              i_clk       = 1'b0;
    logic                              i_rst_n     = 1'b0;
    logic                              i_cfg_wr_en = 1'b0;
    logic [lvnc_pkg::CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [DATA_W-1:0]                 i_cfg_wdata = '0;
    logic                              i_s_tvalid  = 1'b0;
    logic                              o_s_tready;
    logic [PW-1:0]                     i_s_tdata   = '0;   // [7:0] pixel
    logic                              o_m_tvalid;
    logic                              i_m_tready  = 1'b0;
    logic [lvnc_pkg::OUT_W-1:0]        o_m_tdata;  // [22:0] noisy_count, [23] noise_found

    // stimulus bookkeeping
    logic [PW-1:0]    pixel_q[$];
    t_frame_result    frame_result_q[$];
    int               pixels_queued   = 0;
    int               pixels_accepted = 0;
    int               send_idle_pct   = 24;
    int               recv_idle_pct   = 52;
    int               hold_requests   = 0;
    int               holds_served    = 0;
    int               hold_left       = 0;
    int               error_count     = 0;
    int               cycle_count     = 0;

    // predictor state: register copies, line memory, scan position, tally
    logic [lvnc_pkg::GEOM_W-1:0]  reg_width       = lvnc_pkg::RST_FRAME_WIDTH;
    logic [lvnc_pkg::GEOM_W-1:0]  reg_height      = lvnc_pkg::RST_FRAME_HEIGHT;
    logic [lvnc_pkg::DEV_W-1:0]   reg_dev_limit   = lvnc_pkg::RST_DEV_LIMIT;
    logic [lvnc_pkg::COUNT_W-1:0] reg_count_limit = lvnc_pkg::RST_COUNT_LIMIT;
    logic [PW-1:0]                line_mem [3][LINE_MAX];
    int                           frame_w   = 1920;
    int                           frame_h   = 1200;
    int                           col_at    = 0;
    int                           row_at    = 0;
    int unsigned                  noisy_run = 0;

    local_variance_noise_counter #(
        .MAX_WIDTH (LINE_MAX)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // zero means one, and a width is capped at the line length
    function automatic int clamp_size(int raw, int cap);
        if (raw == 0) return 1;
        if (raw > cap) return cap;
        return raw;
    endfunction

    // decide one pixel from the in-image part of its 3x3 neighborhood
    function automatic void judge_pixel(int r, int c);
        int          dr;
        int          dc;
        int unsigned total;
        int unsigned n;
        int unsigned mean;
        int unsigned p;
        int unsigned d;
        total = 0;
        n = 0;
        for (dr = -1; dr <= 1; dr++) begin
            for (dc = -1; dc <= 1; dc++) begin
                if (r + dr >= 0 && c + dc >= 0 && r + dr < frame_h && c + dc < frame_w) begin
                    total += 32'(line_mem[(r + dr) % 3][c + dc]);
                    n++;
                end
            end
        end
        mean = total / n;
        p = 32'(line_mem[r % 3][c]);
        d = (p >= mean) ? p - mean : mean - p;
        if (d * d > 32'(reg_dev_limit) && noisy_run < 32'(lvnc_pkg::TALLY_MAX))
            noisy_run++;
    endfunction

    // advance the predictor by one accepted pixel
    function automatic void take_pixel(logic [PW-1:0] pix);
        int            r;
        int            c;
        int            k;
        t_frame_result res;
        if (row_at == 0 && col_at == 0) begin
            frame_w = clamp_size(int'(reg_width), LINE_MAX);
            frame_h = clamp_size(int'(reg_height), 1 << lvnc_pkg::GEOM_W);
        end
        r = row_at;
        c = col_at;
        line_mem[r % 3][c] = pix;
        if (r >= 1 && c >= 1)
            judge_pixel(r - 1, c - 1);
        if (r >= 1 && c + 1 == frame_w)
            judge_pixel(r - 1, c);
        if (c + 1 >= frame_w) begin
            col_at = 0;
            if (r + 1 >= frame_h) begin
                for (k = 0; k < frame_w; k++)
                    judge_pixel(r, k);
                res.noisy_count = noisy_run[lvnc_pkg::COUNT_W-1:0];
                res.noise_found = (noisy_run > 32'(reg_count_limit));
                frame_result_q.push_back(res);
                noisy_run = 0;
                row_at = 0;
            end else begin
                row_at = r + 1;
            end
        end else begin
            col_at = c + 1;
        end
    endfunction

    // pixel source: hold the beat until taken, then pop the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                take_pixel(i_s_tdata);
                pixels_accepted++;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (pixel_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= pixel_q.pop_front();
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result sink: check each beat, stall at random or for a long hold
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (frame_result_q.size() == 0) begin
                    $error("unexpected result beat: noisy_count %0d, noise_found %0d",
                           o_m_tdata[lvnc_pkg::COUNT_W-1:0], o_m_tdata[lvnc_pkg::COUNT_W]);
                    error_count++;
                end else begin
                    if (o_m_tdata[lvnc_pkg::COUNT_W-1:0] !== frame_result_q[0].noisy_count) begin
                        $error("noisy_count mismatch: expected %0d, actual %0d",
                               frame_result_q[0].noisy_count,
                               o_m_tdata[lvnc_pkg::COUNT_W-1:0]);
                        error_count++;
                    end
                    if (o_m_tdata[lvnc_pkg::COUNT_W] !== frame_result_q[0].noise_found) begin
                        $error("noise_found mismatch: expected %0d, actual %0d",
                               frame_result_q[0].noise_found, o_m_tdata[lvnc_pkg::COUNT_W]);
                        error_count++;
                    end
                    void'(frame_result_q.pop_front());
                end
            end
            if (holds_served < hold_requests) begin
                holds_served++;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [lvnc_pkg::CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        case (idx)
            lvnc_pkg::CFG_FRAME_WIDTH:  reg_width       = val[lvnc_pkg::GEOM_W-1:0];
            lvnc_pkg::CFG_FRAME_HEIGHT: reg_height      = val[lvnc_pkg::GEOM_W-1:0];
            lvnc_pkg::CFG_DEV_LIMIT:    reg_dev_limit   = val[lvnc_pkg::DEV_W-1:0];
            lvnc_pkg::CFG_COUNT_LIMIT:  reg_count_limit = val[lvnc_pkg::COUNT_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic write_setting(int w, int h, int dev, int lim);
        write_reg(lvnc_pkg::CFG_FRAME_WIDTH, DATA_W'(w));
        write_reg(lvnc_pkg::CFG_FRAME_HEIGHT, DATA_W'(h));
        write_reg(lvnc_pkg::CFG_DEV_LIMIT, DATA_W'(dev));
        write_reg(lvnc_pkg::CFG_COUNT_LIMIT, DATA_W'(lim));
    endtask

    task automatic queue_pixel(logic [PW-1:0] pix);
        pixel_q.push_back(pix);
        pixels_queued++;
    endtask

    // wait for every pixel to be taken and every frame result to arrive
    task automatic wait_quiet(int extra);
        while (pixels_accepted != pixels_queued || frame_result_q.size() != 0)
            @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    // flat image, with or without jitter and salt-and-pepper spikes, or plain noise
    function automatic logic [PW-1:0] gen_pixel(int mode, int level);
        int jitter;
        int v;
        jitter = $urandom_range(0, 12);
        case (mode)
            0: return PW'($urandom_range(0, 255));
            1: begin
                if ($urandom_range(0, 7) == 0)
                    return $urandom_range(0, 1) ? 8'hFF : 8'h00;
                v = level + jitter - 6;
                if (v < 0) v = 0;
                if (v > 255) v = 255;
                return PW'(v);
            end
            default: return PW'(level);
        endcase
    endfunction

    // queue whole frames of the current setting, return the pixel count
    task automatic queue_frames(int nframes, output int npix);
        int w;
        int h;
        int mode;
        int level;
        int f;
        int i;
        w = clamp_size(int'(reg_width), LINE_MAX);
        h = clamp_size(int'(reg_height), 1 << lvnc_pkg::GEOM_W);
        npix = 0;
        for (f = 0; f < nframes; f++) begin
            mode  = ($urandom_range(0, 3) == 0) ? 0 : (($urandom_range(0, 7) == 0) ? 2 : 1);
            level = $urandom_range(0, 255);
            for (i = 0; i < w * h; i++)
                queue_pixel(gen_pixel(mode, level));
            npix += w * h;
        end
    endtask

    function automatic int pick_dev_limit();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 65535;
            2, 3:    return $urandom_range(0, 400);
            4:       return $urandom_range(0, 65535);
            default: return $urandom_range(400, 5000);
        endcase
    endfunction

    function automatic int pick_count_limit();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return 23'h7FFFFF;
            2:       return 4194304;
            default: return $urandom_range(0, 20);
        endcase
    endfunction

    function automatic int pick_size(int hi);
        return ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, hi);
    endfunction

    initial begin
        int rand_pixels;
        int rand_frames;
        int npix;
        int nframes;
        rand_pixels = 0;
        rand_frames = 0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero geometry falls back to single-pixel frames
        write_setting(0, 0, 0, 0);
        queue_pixel(8'hFF);
        queue_pixel(8'h00);
        wait_quiet(SETTLE_WAIT);

        // lone bright pixel in a 3x3 frame: corners, edges and center
        write_setting(3, 3, 0, 0);
        queue_pixel(8'h00); queue_pixel(8'h00); queue_pixel(8'h00);
        queue_pixel(8'h00); queue_pixel(8'hFF); queue_pixel(8'h00);
        queue_pixel(8'h00); queue_pixel(8'h00); queue_pixel(8'h00);
        wait_quiet(SETTLE_WAIT);

        // all corners, limit beyond any square
        write_setting(2, 2, 65535, 23'h7FFFFF);
        queue_pixel(8'h00); queue_pixel(8'hFF); queue_pixel(8'hFF); queue_pixel(8'h00);
        wait_quiet(SETTLE_WAIT);

        // single column, then single row
        write_setting(1, 3, 100, 1);
        queue_pixel(8'd10); queue_pixel(8'd200); queue_pixel(8'd10);
        wait_quiet(SETTLE_WAIT);
        write_setting(3, 1, 100, 0);
        queue_pixel(8'hFF); queue_pixel(8'h00); queue_pixel(8'hFF);
        wait_quiet(SETTLE_WAIT);

        // random settings on small frames
        while (rand_pixels < RAND_PIXELS || rand_frames < RAND_FRAMES) begin
            if (rand_pixels < RAND_PIXELS / 3) begin
                send_idle_pct = 24;
                recv_idle_pct = 52;
            end else if (rand_pixels < 2 * RAND_PIXELS / 3) begin
                send_idle_pct = 52;
                recv_idle_pct = 24;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_setting(pick_size(12), pick_size(10), pick_dev_limit(),
                          pick_count_limit());
            nframes = $urandom_range(1, 4);
            queue_frames(nframes, npix);
            rand_pixels += npix;
            rand_frames += nframes;
            wait_quiet(SETTLE_WAIT);
        end

        // hold the result side off while tiny frames keep coming
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_setting(2, 2, $urandom_range(0, 200), $urandom_range(0, 3));
        hold_requests++;
        queue_frames(12, npix);
        wait_quiet(DRAIN_WAIT);

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* files.f */
sv/lvnc_pkg.sv
sv/lvnc_ram.sv
sv/lvnc_judge.sv
sv/local_variance_noise_counter.sv
sv/lvnc_checker.sv
bench/tb_local_variance_noise_counter.sv
